// ----- rtl/core/ile_pkg.sv -----
// ----------------------------------------------------------------------------
// ile_pkg
// shared codes and word types of the indexed list engine
// ----------------------------------------------------------------------------
package ile_pkg;

  // command codes of the input word
  typedef enum logic [2:0] {
    CMD_GET    = 3'd0,
    CMD_HEAD   = 3'd1,
    CMD_TAIL   = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_DELETE = 3'd4
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // input word
  typedef struct packed {
    logic [2:0]         command;
    logic [7:0]         position;
    logic signed [31:0] value;
  } req_t;

  // result word
  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [6:0]         length;
  } res_t;

endpackage

// ----- rtl/core/ile_ifs.sv -----
// ----------------------------------------------------------------------------
// ile_in_if / ile_out_if
// valid/ready channels for command words and result words
// ----------------------------------------------------------------------------
interface ile_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [7:0]         position;
  logic signed [31:0] value;

  modport source (output valid, command, position, value, input ready);
  modport sink (input valid, command, position, value, output ready);
endinterface

interface ile_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic [1:0]         status;
  logic [6:0]         length;

  modport source (output valid, read_value, status, length, input ready);
  modport sink (input valid, read_value, status, length, output ready);
endinterface

// ----- rtl/core/ile_ram.sv -----
// ----------------------------------------------------------------------------
// ile_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ile_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/ile_seq.sv -----
// ----------------------------------------------------------------------------
// ile_seq
// command sequencer: walks the link memory and edits the list in place
// ----------------------------------------------------------------------------
module ile_seq #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  output logic          req_ready,
  input  ile_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output ile_pkg::res_t res
);
  import ile_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_EXEC, S_WALK, S_GETW, S_MID1, S_DEL0, S_DEL1,
    S_DEL2, S_DEL3, S_TAKE, S_TAKE2, S_RESP
  } state_t;

  typedef enum logic [2:0] {
    OP_GET, OP_HEAD, OP_TAIL, OP_MID, OP_DEL
  } op_t;

  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [AW-1:0]         init_r, init_nxt;
  logic [AW-1:0]         first_r, first_nxt;
  logic [AW-1:0]         last_r, last_nxt;
  logic [AW-1:0]         free_r, free_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  pend_r, pend_nxt;
  logic [2:0]            cmd_r, cmd_nxt;
  logic [7:0]            pos_r, pos_nxt;
  logic [VALUE_BITS-1:0] word_r, word_nxt;
  logic [AW-1:0]         rem_r, rem_nxt;
  logic [AW-1:0]         node_r, node_nxt;
  logic [AW-1:0]         tgt_r, tgt_nxt;
  logic [AW-1:0]         lnk_r, lnk_nxt;
  logic [AW-1:0]         vic_r, vic_nxt;
  logic signed [31:0]    rv_r, rv_nxt;
  status_t               status_r, status_nxt;

  logic                  link_we, link_re;
  logic [AW-1:0]         link_waddr, link_wdata, link_raddr, link_rdata;
  logic                  val_we, val_re;
  logic [AW-1:0]         val_waddr, val_raddr;
  logic [VALUE_BITS-1:0] val_rdata;

  logic [AW-1:0]         node;
  logic [CMPW-1:0]       pos_w, cnt_w;
  logic                  full;
  logic [63:0]           in_ext, rd_ext;

  // link and value memories
  ile_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wdata),
    .rd_en   (link_re),
    .rd_addr (link_raddr),
    .rd_data (link_rdata)
  );

  ile_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val_ram (
    .clk     (clk),
    .wr_en   (val_we),
    .wr_addr (val_waddr),
    .wr_data (word_r),
    .rd_en   (val_re),
    .rd_addr (val_raddr),
    .rd_data (val_rdata)
  );

  // current walk position: fresh link data while a read is in flight
  assign node  = pend_r ? link_rdata : node_r;
  assign pos_w = CMPW'(pos_r);
  assign cnt_w = CMPW'(count_r);
  assign full  = (count_r == CW'(CAPACITY));

  // word width conversion on store and load
  assign in_ext = 64'(signed'(req.value));
  assign rd_ext = 64'(signed'(val_rdata));

  assign res.read_value = rv_r;
  assign res.status     = status_r;
  assign res.length     = 7'(count_r);

  // next state and memory port control
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    init_nxt   = init_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    free_nxt   = free_r;
    count_nxt  = count_r;
    pend_nxt   = pend_r;
    cmd_nxt    = cmd_r;
    pos_nxt    = pos_r;
    word_nxt   = word_r;
    rem_nxt    = rem_r;
    node_nxt   = node_r;
    tgt_nxt    = tgt_r;
    lnk_nxt    = lnk_r;
    vic_nxt    = vic_r;
    rv_nxt     = rv_r;
    status_nxt = status_r;
    link_we    = 1'b0;
    link_waddr = '0;
    link_wdata = '0;
    link_re    = 1'b0;
    link_raddr = '0;
    val_we     = 1'b0;
    val_waddr  = '0;
    val_re     = 1'b0;
    val_raddr  = '0;
    req_ready  = 1'b0;
    res_valid  = 1'b0;

    case (state_r)
      // chain every slot into the free list after reset
      S_INIT: begin
        link_we    = 1'b1;
        link_waddr = init_r;
        link_wdata = (init_r == AW'(CAPACITY - 1)) ? '0 : init_r + AW'(1);
        init_nxt   = init_r + AW'(1);
        if (init_r == AW'(CAPACITY - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd_nxt   = req.command;
          pos_nxt   = req.position;
          word_nxt  = in_ext[VALUE_BITS-1:0];
          state_nxt = S_EXEC;
        end
      end

      // range and capacity checks, then pick the edit sequence
      S_EXEC: begin
        status_nxt = ST_DONE;
        rv_nxt     = '0;
        pend_nxt   = 1'b0;
        node_nxt   = first_r;
        state_nxt  = S_RESP;
        case (cmd_r)
          CMD_GET: begin
            if (pos_w < cnt_w) begin
              op_nxt    = OP_GET;
              rem_nxt   = AW'(pos_r);
              state_nxt = S_WALK;
            end else begin
              rv_nxt     = '1;
              status_nxt = ST_INVALID;
            end
          end
          CMD_HEAD, CMD_TAIL: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              op_nxt     = (cmd_r == CMD_HEAD) ? OP_HEAD : OP_TAIL;
              link_re    = 1'b1;
              link_raddr = free_r;
              state_nxt  = S_TAKE;
            end
          end
          CMD_INSERT: begin
            if (pos_w > cnt_w) begin
              status_nxt = ST_INVALID;
            end else if (full) begin
              status_nxt = ST_FULL;
            end else if (pos_r == 8'd0 || pos_w == cnt_w) begin
              op_nxt     = (pos_r == 8'd0) ? OP_HEAD : OP_TAIL;
              link_re    = 1'b1;
              link_raddr = free_r;
              state_nxt  = S_TAKE;
            end else begin
              op_nxt    = OP_MID;
              rem_nxt   = AW'(pos_r - 8'd1);
              state_nxt = S_WALK;
            end
          end
          CMD_DELETE: begin
            if (pos_w >= cnt_w) begin
              status_nxt = ST_INVALID;
            end else if (pos_r == 8'd0) begin
              link_re    = 1'b1;
              link_raddr = first_r;
              state_nxt  = S_DEL0;
            end else begin
              op_nxt    = OP_DEL;
              rem_nxt   = AW'(pos_r - 8'd1);
              state_nxt = S_WALK;
            end
          end
          default: begin
            status_nxt = ST_INVALID;
          end
        endcase
      end

      // follow links, one link read per cycle
      S_WALK: begin
        if (rem_r != '0) begin
          link_re    = 1'b1;
          link_raddr = node;
          node_nxt   = node;
          pend_nxt   = 1'b1;
          rem_nxt    = rem_r - AW'(1);
        end else begin
          pend_nxt = 1'b0;
          tgt_nxt  = node;
          case (op_r)
            OP_GET: begin
              val_re    = 1'b1;
              val_raddr = node;
              state_nxt = S_GETW;
            end
            OP_MID: begin
              link_re    = 1'b1;
              link_raddr = node;
              state_nxt  = S_MID1;
            end
            OP_DEL: begin
              link_re    = 1'b1;
              link_raddr = node;
              state_nxt  = S_DEL1;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_GETW: begin
        rv_nxt    = rd_ext[31:0];
        state_nxt = S_RESP;
      end

      // successor of the predecessor is in hand, now pop a free slot
      S_MID1: begin
        lnk_nxt    = link_rdata;
        link_re    = 1'b1;
        link_raddr = free_r;
        state_nxt  = S_TAKE;
      end

      // unlink the head element
      S_DEL0: begin
        vic_nxt   = first_r;
        first_nxt = link_rdata;
        if (count_r == CW'(1)) begin
          last_nxt = link_rdata;
        end
        state_nxt = S_DEL3;
      end

      // victim found behind the predecessor, fetch its successor
      S_DEL1: begin
        vic_nxt    = link_rdata;
        link_re    = 1'b1;
        link_raddr = link_rdata;
        state_nxt  = S_DEL2;
      end

      S_DEL2: begin
        link_we    = 1'b1;
        link_waddr = tgt_r;
        link_wdata = link_rdata;
        if (pos_w == cnt_w - CMPW'(1)) begin
          last_nxt = tgt_r;
        end
        state_nxt = S_DEL3;
      end

      // return the victim to the free list
      S_DEL3: begin
        link_we    = 1'b1;
        link_waddr = vic_r;
        link_wdata = free_r;
        free_nxt   = vic_r;
        count_nxt  = count_r - CW'(1);
        state_nxt  = S_RESP;
      end

      // pop the free slot, store the word and hook the slot in
      S_TAKE: begin
        free_nxt  = link_rdata;
        val_we    = 1'b1;
        val_waddr = free_r;
        vic_nxt   = free_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_RESP;
        case (op_r)
          OP_HEAD: begin
            link_we    = 1'b1;
            link_waddr = free_r;
            link_wdata = first_r;
            first_nxt  = free_r;
            if (count_r == '0) begin
              last_nxt = free_r;
            end
          end
          OP_TAIL: begin
            if (count_r == '0) begin
              first_nxt = free_r;
            end else begin
              link_we    = 1'b1;
              link_waddr = last_r;
              link_wdata = free_r;
            end
            last_nxt = free_r;
          end
          OP_MID: begin
            link_we    = 1'b1;
            link_waddr = free_r;
            link_wdata = lnk_r;
            state_nxt  = S_TAKE2;
          end
          default: begin
            count_nxt = count_r;
          end
        endcase
      end

      // point the predecessor at the new slot
      S_TAKE2: begin
        link_we    = 1'b1;
        link_waddr = tgt_r;
        link_wdata = vic_r;
        state_nxt  = S_RESP;
      end

      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    cmd_r    <= cmd_nxt;
    pos_r    <= pos_nxt;
    word_r   <= word_nxt;
    rem_r    <= rem_nxt;
    node_r   <= node_nxt;
    tgt_r    <= tgt_nxt;
    lnk_r    <= lnk_nxt;
    vic_r    <= vic_nxt;
    rv_r     <= rv_nxt;
    status_r <= status_nxt;
    if (!rst_n) begin
      state_r <= S_INIT;
      init_r  <= '0;
      first_r <= '0;
      last_r  <= '0;
      free_r  <= '0;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      free_r  <= free_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

// ----- rtl/core/indexed_list_engine.sv -----
// ----------------------------------------------------------------------------
// indexed_list_engine
// ordered list of signed words kept as a linked list in two memories
// ----------------------------------------------------------------------------
// The engine holds up to CAPACITY words in a value memory and a link memory,
// with unused slots on a free list, and runs one command word at a time: get,
// insert at head, append at tail, insert before a position, delete at a
// position. Each command returns one result word with the read value, a
// status and the length after the command. After reset the engine chains the
// link memory into the free list and takes no command word in that time. A
// get walks from the head to its position, and a middle insert or a delete
// past the head walks to the predecessor; an insert at position 0 or at the
// length runs as a head or tail insert and a delete at the head needs no walk.
// The walk reads the link memory once per cycle through its single read port.
// The result sits in an output register, so the next command word is taken
// while a result still waits for the sink; a second finished result holds the
// engine in its response state until that word leaves.
module indexed_list_engine #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  ile_in_if.sink     in_ch,
  ile_out_if.source  out_ch
);
  import ile_pkg::*;

  req_t req;
  res_t res;
  logic res_valid, res_ready;
  res_t out_data_r, out_data_nxt;
  logic out_valid_r, out_valid_nxt;

  assign req.command  = in_ch.command;
  assign req.position = in_ch.position;
  assign req.value    = in_ch.value;

  ile_seq #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_ch.valid),
    .req_ready (in_ch.ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register, refilled as soon as the sink takes its word
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_data_r.read_value;
  assign out_ch.status     = out_data_r.status;
  assign out_ch.length     = out_data_r.length;

endmodule

// ----- rtl/core/ile_chk.sv -----
// ----------------------------------------------------------------------------
// ile_chk
// port-level checks of the indexed list engine, bound to the top level
// ----------------------------------------------------------------------------
module ile_chk #(
  parameter int CAPACITY = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_read_value,
  input logic [1:0]  out_status,
  input logic [6:0]  out_length
);
  import ile_pkg::*;

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_read_value) && $stable(out_status)
      && $stable(out_length))
    else $error("result word changed while stalled");

  // one command at a time: no word taken right after another
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command word taken while one is in progress");

  // a full status reports a full list and no read value
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |->
      out_length == 7'(CAPACITY) && out_read_value == 32'd0)
    else $error("full status with wrong length or value");

  // length never exceeds the capacity
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CAPACITY > 127) || (32'(out_length) <= 32'(CAPACITY)))
    else $error("length above capacity");

endmodule

bind indexed_list_engine ile_chk #(.CAPACITY(CAPACITY)) u_ile_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_read_value (out_ch.read_value),
  .out_status     (out_ch.status),
  .out_length     (out_ch.length)
);
